// ----- rtl/core/prs_pkg.sv -----
// polled request scheduler package: item kinds, controller states, cell link structs
// no dependencies
package prs_pkg;

    typedef enum logic [3:0] {
        KIND_REGISTER = 4'd0,
        KIND_CLEAR    = 4'd1,
        KIND_DISABLE  = 4'd2,
        KIND_ENABLE   = 4'd3,
        KIND_BYPASS   = 4'd4,
        KIND_RESPONSE = 4'd5,
        KIND_TIMEOUT  = 4'd6,
        KIND_NEXT     = 4'd7,
        KIND_SEND     = 4'd8
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_SCAN,
        ST_SEND,
        ST_DONE
    } state_t;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic        wr_new;      // register into the cell whose index equals count
        logic        off_set;     // disable on match
        logic        off_clr;     // enable on match
        logic        bypass;      // clear last time on match
        logic        resp;        // response on match
        logic        tmo;         // soft timeout on match and waiting
        logic        send;        // direct send on match
        logic        scan;        // next-after scan active
        logic [7:0]  code;
        logic [31:0] now;
        logic [15:0] mask;
        logic [31:0] new_interval;
        logic [15:0] new_timeout;
        logic [7:0]  new_limit;
    } bcast_t;

    // ripple token between neighboring cells
    typedef struct packed {
        logic found;    // an earlier cell already claimed the action
        logic seen;     // an earlier cell already holds the code
        logic armed;    // scan may take the next qualifying cell
    } chain_t;

    // reply from a cell
    typedef struct packed {
        logic        hit;
        logic        first;
        logic        sent;
        logic        off_now;
        logic [7:0]  code;
        logic [15:0] timeout;
    } reply_t;

endpackage

// ----- rtl/core/polled_request_scheduler.sv -----
// polled request scheduler top level: controller plus a chain of table cells
// depends on prs_pkg, prs_ctrl, prs_cell
// the strobe comes in the done state, after the find pass alone or after find, scan and send
// a new word is taken only in idle, after the last one is done; busy covers all passes
// the find, scan and send passes each ripple once through the cell chain
// reset clears the entry count and controller; the receiver cannot stall the strobe
module polled_request_scheduler #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  kind,
    input  logic [7:0]  code,
    input  logic [31:0] now_ms,
    input  logic [15:0] allowed_mask,
    input  logic [31:0] new_interval_ms,
    input  logic [15:0] new_timeout_ms,
    input  logic [7:0]  new_failure_limit,
    output logic        done,
    output logic        handled,
    output logic        sent_valid,
    output logic [7:0]  sent_code,
    output logic [15:0] arm_timeout_ms,
    output logic        cycle_done,
    output logic        newly_disabled,
    output logic        table_full
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    prs_pkg::state_t state;
    logic            capture, scan_phase, finish;
    logic [IDX_W:0]  count_reg;
    logic [3:0]      kind_reg;
    logic [7:0]      code_reg;
    logic [31:0]     now_reg, interval_reg;
    logic [15:0]     mask_reg, timeout_reg;
    logic [7:0]      limit_reg;
    logic            find_phase;
    logic            send_phase;
    logic            hit;
    logic            found_reg;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] hit_idx_n;
    logic [7:0]      scan_code_reg;
    prs_pkg::bcast_t bc;
    prs_pkg::chain_t chain [TABLE_DEPTH+1];
    prs_pkg::reply_t rep [TABLE_DEPTH];
    prs_pkg::reply_t agg;

    logic        r_handled, r_sent, r_done, r_off, r_full;
    logic [7:0]  r_code;
    logic [15:0] r_tmo;

    assign find_phase = (state == prs_pkg::ST_FIND);
    assign send_phase = (state == prs_pkg::ST_SEND);

    prs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .kind       (kind),
        .hit        (hit),
        .state      (state),
        .capture    (capture),
        .scan_phase (scan_phase),
        .finish     (finish)
    );

    assign busy = (state != prs_pkg::ST_IDLE);

    always_comb
    begin
        bc              = '0;
        // the send pass acts on the first entry holding the scanned code
        bc.code         = send_phase ? scan_code_reg : code_reg;
        bc.now          = now_reg;
        bc.mask         = mask_reg;
        bc.new_interval = interval_reg;
        bc.new_timeout  = timeout_reg;
        bc.new_limit    = limit_reg;
        bc.scan         = scan_phase;
        if (find_phase) begin
            bc.wr_new  = (kind_reg == prs_pkg::KIND_REGISTER) &&
                         (count_reg < (IDX_W+1)'(TABLE_DEPTH));
            bc.off_set = kind_reg == prs_pkg::KIND_DISABLE;
            bc.off_clr = kind_reg == prs_pkg::KIND_ENABLE;
            bc.bypass  = kind_reg == prs_pkg::KIND_BYPASS;
            bc.resp    = kind_reg == prs_pkg::KIND_RESPONSE;
            bc.tmo     = kind_reg == prs_pkg::KIND_TIMEOUT;
            bc.send    = kind_reg == prs_pkg::KIND_SEND;
        end
        if (send_phase)
            bc.send = !r_done;
    end

    assign chain[0].found = 1'b0;
    assign chain[0].seen  = 1'b0;
    assign chain[0].armed = !found_reg;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            prs_pkg::chain_t c_in;
            // token arms right after the cell that held the code
            always_comb
            begin
                c_in = chain[g];
                if (found_reg && hit_idx == IDX_W'(g) - IDX_W'(1) && g > 0)
                    c_in.armed = 1'b1;
            end
            prs_cell #(.IDX_W(IDX_W)) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .idx       (IDX_W'(g)),
                .count     (count_reg),
                .bc        (bc),
                .chain_in  (c_in),
                .chain_out (chain[g+1]),
                .reply     (rep[g])
            );
        end
    endgenerate

    always_comb
    begin
        agg     = '0;
        hit     = 1'b0;
        hit_idx_n = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            agg = agg | rep[i];
            if (rep[i].first)
                hit_idx_n = IDX_W'(i);
        end
        hit = agg.hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= '0;
        end else if (find_phase) begin
            if (kind_reg == prs_pkg::KIND_CLEAR)
                count_reg <= '0;
            else if (bc.wr_new)
                count_reg <= count_reg + (IDX_W+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture) begin
            kind_reg     <= kind;
            code_reg     <= code;
            now_reg      <= now_ms;
            mask_reg     <= allowed_mask;
            interval_reg <= new_interval_ms;
            timeout_reg  <= new_timeout_ms;
            limit_reg    <= new_failure_limit;
        end
        if (find_phase) begin
            found_reg <= agg.first;
            hit_idx   <= hit_idx_n;
            r_handled <= agg.hit && (kind_reg == prs_pkg::KIND_RESPONSE);
            r_off     <= agg.off_now;
            r_full    <= (kind_reg == prs_pkg::KIND_REGISTER) && !bc.wr_new;
            r_sent    <= agg.sent;
            r_code    <= agg.code;
            r_tmo     <= agg.timeout;
            r_done    <= 1'b0;
        end
        if (scan_phase) begin
            scan_code_reg <= agg.code;
            r_done        <= !agg.sent;
        end
        if (send_phase) begin
            r_sent <= agg.sent;
            r_code <= agg.code;
            r_tmo  <= agg.timeout;
        end
    end

    assign done           = finish;
    assign handled        = finish & r_handled;
    assign sent_valid     = finish & r_sent;
    assign sent_code      = finish ? r_code : 8'd0;
    assign arm_timeout_ms = finish ? r_tmo : 16'd0;
    assign cycle_done     = finish & r_done;
    assign newly_disabled = finish & r_off;
    assign table_full     = finish & r_full;

endmodule

// ----- rtl/core/prs_cell.sv -----
// one table entry of the polled request scheduler, with its share of the match chain
// depends on prs_pkg
module prs_cell #(
    parameter int IDX_W = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IDX_W-1:0]      idx,
    input  logic [IDX_W:0]        count,
    input  prs_pkg::bcast_t       bc,
    input  prs_pkg::chain_t       chain_in,
    output prs_pkg::chain_t       chain_out,
    output prs_pkg::reply_t       reply
);

    logic [7:0]  code_reg;
    logic [31:0] interval_reg;
    logic [15:0] timeout_reg;
    logic [7:0]  limit_reg;
    logic [7:0]  fail_reg;
    logic        off_reg;
    logic        wait_reg;
    logic [31:0] last_reg;

    logic        live;
    logic        match;
    logic        allowed;
    logic        due;
    logic        take;
    logic        send_ok;
    logic        act;
    logic [7:0]  fail_inc;
    logic [7:0]  idx_w;

    assign idx_w    = 8'(idx);
    assign live     = {1'b0, idx} < count;
    assign match    = live && (code_reg == bc.code);
    // entries from sixteen up have no mask bit
    assign allowed  = (idx_w >= 8'd16) ? 1'b1 : bc.mask[idx_w[3:0]];
    assign due      = (interval_reg == 32'd0) || (last_reg == 32'd0) ||
                      ((bc.now - last_reg) >= interval_reg);
    assign send_ok  = !off_reg && allowed;
    // scan only names the first qualifying cell after the token is armed
    assign take     = bc.scan && chain_in.armed && !chain_in.found && live && send_ok && due;
    // actions keyed by code act on the first matching cell, timeouts on the first matching waiting one
    assign act      = !chain_in.found && match && (!bc.tmo || wait_reg);
    assign fail_inc = (fail_reg == 8'hff) ? fail_reg : fail_reg + 8'd1;

    always_comb
    begin
        chain_out      = chain_in;
        reply          = '0;
        chain_out.seen = chain_in.seen || match;
        reply.first    = match && !chain_in.seen;
        if (bc.scan) begin
            if (take) begin
                chain_out.found = 1'b1;
                reply.sent      = 1'b1;
                reply.code      = code_reg;
                reply.timeout   = timeout_reg;
            end
        end else if (act) begin
            chain_out.found = 1'b1;
            reply.hit       = 1'b1;
            reply.off_now   = bc.tmo && (fail_inc >= limit_reg);
            if (bc.send && send_ok) begin
                reply.sent    = 1'b1;
                reply.code    = code_reg;
                reply.timeout = timeout_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            off_reg  <= 1'b0;
            wait_reg <= 1'b0;
        end else if (bc.wr_new && ({1'b0, idx} == count)) begin
            off_reg  <= 1'b0;
            wait_reg <= 1'b0;
        end else if (act && bc.send && send_ok) begin
            wait_reg <= 1'b1;
        end else if (act) begin
            if (bc.off_set || (bc.tmo && fail_inc >= limit_reg))
                off_reg <= 1'b1;
            else if (bc.off_clr)
                off_reg <= 1'b0;
            if (bc.resp || bc.tmo)
                wait_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bc.wr_new && ({1'b0, idx} == count)) begin
            code_reg     <= bc.code;
            interval_reg <= bc.new_interval;
            timeout_reg  <= bc.new_timeout;
            limit_reg    <= bc.new_limit;
            fail_reg     <= 8'd0;
            last_reg     <= 32'd0;
        end else if (act && bc.send && send_ok) begin
            last_reg <= bc.now;
        end else if (act) begin
            if (bc.bypass)
                last_reg <= 32'd0;
            if (bc.resp)
                fail_reg <= 8'd0;
            else if (bc.tmo)
                fail_reg <= fail_inc;
        end
    end

endmodule

// ----- rtl/core/prs_ctrl.sv -----
// controller of the polled request scheduler: sequences find, scan and send passes
// depends on prs_pkg
module prs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [3:0]        kind,
    input  logic              hit,
    output prs_pkg::state_t   state,
    output logic              capture,
    output logic              scan_phase,
    output logic              finish
);

    prs_pkg::state_t state_reg, state_next;
    prs_pkg::kind_t  kind_reg;
    logic            need_scan;

    assign state = state_reg;
    assign need_scan = (kind_reg == prs_pkg::KIND_NEXT) ||
                       (hit && (kind_reg == prs_pkg::KIND_RESPONSE ||
                                kind_reg == prs_pkg::KIND_TIMEOUT));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            prs_pkg::ST_IDLE: if (start) state_next = prs_pkg::ST_FIND;
            prs_pkg::ST_FIND: state_next = need_scan ? prs_pkg::ST_SCAN : prs_pkg::ST_DONE;
            prs_pkg::ST_SCAN: state_next = prs_pkg::ST_SEND;
            prs_pkg::ST_SEND: state_next = prs_pkg::ST_DONE;
            prs_pkg::ST_DONE: state_next = prs_pkg::ST_IDLE;
            default:          state_next = prs_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        capture    = 1'b0;
        scan_phase = 1'b0;
        finish     = 1'b0;
        case (state_reg)
            prs_pkg::ST_IDLE: capture    = start;
            prs_pkg::ST_SCAN: scan_phase = 1'b1;
            prs_pkg::ST_DONE: finish     = 1'b1;
            default:          ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= prs_pkg::ST_IDLE;
            kind_reg  <= prs_pkg::KIND_CLEAR;
        end else begin
            state_reg <= state_next;
            if (capture)
                kind_reg <= prs_pkg::kind_t'(kind);
        end
    end

endmodule
